/* design/lz4_block_decoder_macros.svh */
// Assertion helpers for the LZ4 block decoder.
`ifndef LZ4_BLOCK_DECODER_MACROS_SVH
`define LZ4_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZ4BD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lz4 block decoder check failed");

// Next-cycle implication, disabled during reset.
`define LZ4BD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lz4 block decoder check failed");

`endif

/* design/lz4bd_pkg.sv */
`default_nettype none

package lz4bd_pkg;

  localparam int unsigned MAX_BLOCK_DEF = 65536;
  localparam int unsigned CAP_W         = 17;
  localparam int unsigned HIST_AW       = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

  localparam logic [3:0] NIB_EXT   = 4'd15;
  localparam logic [7:0] EXT_CONT  = 8'd255;
  localparam int unsigned MIN_MATCH = 4;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OFFSET   = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_TRUNC    = 3'd3;
  localparam logic [2:0] ERR_BUSY     = 3'd4;

  localparam logic CFG_STORED   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef struct packed {
    logic               emit;
    logic               copy;
    logic [7:0]         lit;
    logic [HIST_AW-1:0] waddr;
    logic               busy;
    logic               done;
    logic [2:0]         err;
    logic [CAP_W-1:0]   len;
  } step_t;

endpackage

`default_nettype wire

/* design/lz4bd_in_if.sv */
`default_nettype none

interface lz4bd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output op, output data_byte, output last, input ready);
  modport sink   (input valid, input op, input data_byte, input last, output ready);
endinterface

`default_nettype wire

/* design/lz4bd_out_if.sv */
`default_nettype none

interface lz4bd_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        busy_res;
  logic        block_done;
  logic [2:0]  error_code;
  logic [16:0] decoded_length;

  modport source (output valid, output out_valid, output out_byte, output busy_res,
                  output block_done, output error_code, output decoded_length,
                  input ready);
  modport sink   (input valid, input out_valid, input out_byte, input busy_res,
                  input block_done, input error_code, input decoded_length,
                  output ready);
endinterface

`default_nettype wire

/* design/lz4_block_decoder.sv */
// An accepted transaction is registered in stage s1 and then in the output register.
// Throughput: one byte or drain tick per cycle unless output stalls; history memory is
// read on acceptance, written as s1 advances, with a forward path for the same entry.
// Reset: asynchronous, active low; clears parser state, pipeline valids and
// configuration. History contents stay undefined until written.
`default_nettype none

module lz4_block_decoder #(
  parameter int unsigned MAX_BLOCK = lz4bd_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [lz4bd_pkg::CAP_W-1:0] cfg_data_i,
  lz4bd_in_if.sink                         in_i,
  lz4bd_out_if.source                      out_o
);

  logic                        stored_q;
  logic [lz4bd_pkg::CAP_W-1:0] capacity_q;

  logic                          in_ready;
  logic                          acc;
  lz4bd_pkg::step_t              step;
  lz4bd_pkg::step_t              res;
  logic [lz4bd_pkg::HIST_AW-1:0] rd_addr;
  logic                          res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q   <= 1'b0;
      capacity_q <= lz4bd_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lz4bd_pkg::CFG_STORED:   stored_q   <= cfg_data_i[0];
        lz4bd_pkg::CFG_CAPACITY: capacity_q <= cfg_data_i;
        default:                 stored_q   <= stored_q;
      endcase
    end
  end

  assign acc        = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  lz4bd_parser #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .op_i        (in_i.op),
    .data_byte_i (in_i.data_byte),
    .last_i      (in_i.last),
    .stored_i    (stored_q),
    .capacity_i  (capacity_q),
    .step_o      (step),
    .rd_addr_o   (rd_addr)
  );

  lz4bd_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .step_i      (step),
    .rd_addr_i   (rd_addr),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (res_valid),
    .out_o       (res)
  );

  assign out_o.valid          = res_valid;
  assign out_o.out_valid      = res.emit;
  assign out_o.out_byte       = res.lit;
  assign out_o.busy_res       = res.busy;
  assign out_o.block_done     = res.done;
  assign out_o.error_code     = res.err;
  assign out_o.decoded_length = res.len;

endmodule

`default_nettype wire

/* design/lz4bd_parser.sv */
`default_nettype none

module lz4bd_parser #(
  parameter int unsigned MAX_BLOCK = lz4bd_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             acc_i,
  input  wire logic                             op_i,
  input  wire logic [7:0]                       data_byte_i,
  input  wire logic                             last_i,
  input  wire logic                             stored_i,
  input  wire logic [lz4bd_pkg::CAP_W-1:0]      capacity_i,
  output lz4bd_pkg::step_t                      step_o,
  output logic      [lz4bd_pkg::HIST_AW-1:0]    rd_addr_o
);

  localparam logic [2:0] PH_TOKEN     = 3'd0;
  localparam logic [2:0] PH_LIT_EXT   = 3'd1;
  localparam logic [2:0] PH_LITERALS  = 3'd2;
  localparam logic [2:0] PH_OFF_LO    = 3'd3;
  localparam logic [2:0] PH_OFF_HI    = 3'd4;
  localparam logic [2:0] PH_MATCH_EXT = 3'd5;
  localparam logic [2:0] PH_COPY      = 3'd6;
  localparam logic [2:0] PH_STORED    = 3'd7;

  localparam int unsigned CW = lz4bd_pkg::CAP_W;

  logic [2:0]    ph_q, ph_d;
  logic [3:0]    nib_q, nib_d;
  logic [CW-1:0] lrem_q, lrem_d;
  logic [CW-1:0] mrem_q, mrem_d;
  logic [15:0]   off_q, off_d;
  logic [CW-1:0] wp_q, wp_d;
  logic [2:0]    err_q, err_d;
  logic          end_q, end_d;

  logic [CW-1:0] lim;

  assign lim = (32'(capacity_i) > 32'(MAX_BLOCK)) ? CW'(MAX_BLOCK) : capacity_i;
  assign rd_addr_o = wp_q[lz4bd_pkg::HIST_AW-1:0] - off_q;

  always_comb begin
    logic [CW-1:0] room;
    logic [CW:0]   sum;
    logic [CW:0]   mlen;
    logic          mmore;
    logic [2:0]    fcode;
    logic          bnd;
    logic          emit;
    logic          copy;
    logic [lz4bd_pkg::HIST_AW-1:0] waddr;

    ph_d   = ph_q;
    nib_d  = nib_q;
    lrem_d = lrem_q;
    mrem_d = mrem_q;
    off_d  = off_q;
    wp_d   = wp_q;
    err_d  = err_q;
    end_d  = end_q;
    room   = '0;
    sum    = '0;
    mlen   = '0;
    mmore  = 1'b0;
    fcode  = lz4bd_pkg::ERR_NONE;
    bnd    = 1'b0;
    emit   = 1'b0;
    copy   = 1'b0;
    waddr  = wp_q[lz4bd_pkg::HIST_AW-1:0];

    if (op_i) begin
      if (ph_q == PH_COPY && err_q == lz4bd_pkg::ERR_NONE) begin
        emit = 1'b1;
        copy = 1'b1;
        wp_d = wp_q + 1'b1;
        if (mrem_d != '0) mrem_d = mrem_d - 1'b1;
        if (mrem_d == '0) ph_d = PH_TOKEN;
      end
    end else if (ph_q == PH_COPY) begin
      if (err_q == lz4bd_pkg::ERR_NONE) err_d = lz4bd_pkg::ERR_BUSY;
      ph_d   = PH_TOKEN;
      mrem_d = '0;
      lrem_d = '0;
      if (last_i) end_d = 1'b1;
    end else begin
      if (end_q) begin
        ph_d   = PH_TOKEN;
        wp_d   = '0;
        err_d  = lz4bd_pkg::ERR_NONE;
        end_d  = 1'b0;
        mrem_d = '0;
        lrem_d = '0;
      end
      if (err_d == lz4bd_pkg::ERR_NONE) begin
        if (ph_d == PH_TOKEN && wp_d == '0 && stored_i) ph_d = PH_STORED;
        room  = (wp_d >= lim) ? '0 : lim - wp_d;
        waddr = wp_d[lz4bd_pkg::HIST_AW-1:0];
        case (ph_d)
          PH_STORED: begin
            if (room == '0) begin
              fcode = lz4bd_pkg::ERR_OVERFLOW;
            end else begin
              emit = 1'b1;
              wp_d = wp_d + 1'b1;
              bnd  = 1'b1;
            end
          end
          PH_TOKEN: begin
            nib_d = data_byte_i[3:0];
            if (data_byte_i[7:4] == 4'd0) begin
              ph_d = PH_OFF_LO;
              bnd  = 1'b1;
            end else if (CW'(data_byte_i[7:4]) > room) begin
              fcode = lz4bd_pkg::ERR_OVERFLOW;
            end else begin
              lrem_d = CW'(data_byte_i[7:4]);
              ph_d   = (data_byte_i[7:4] == lz4bd_pkg::NIB_EXT) ? PH_LIT_EXT : PH_LITERALS;
            end
          end
          PH_LIT_EXT: begin
            sum = (CW+1)'(lrem_d) + (CW+1)'(data_byte_i);
            if (sum > (CW+1)'(room)) begin
              fcode = lz4bd_pkg::ERR_OVERFLOW;
            end else begin
              lrem_d = sum[CW-1:0];
              if (data_byte_i != lz4bd_pkg::EXT_CONT) ph_d = PH_LITERALS;
            end
          end
          PH_LITERALS: begin
            emit = 1'b1;
            wp_d = wp_d + 1'b1;
            if (lrem_d != '0) lrem_d = lrem_d - 1'b1;
            if (lrem_d == '0) begin
              ph_d = PH_OFF_LO;
              bnd  = 1'b1;
            end
          end
          PH_OFF_LO: begin
            off_d = {8'd0, data_byte_i};
            ph_d  = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            off_d = {data_byte_i, off_q[7:0]};
            if (off_d == '0 || CW'(off_d) > wp_d) begin
              fcode = lz4bd_pkg::ERR_OFFSET;
            end else begin
              if (nib_q == lz4bd_pkg::NIB_EXT) begin
                mlen  = (CW+1)'(lz4bd_pkg::NIB_EXT) + (CW+1)'(lz4bd_pkg::MIN_MATCH);
                mmore = 1'b1;
              end else begin
                mlen  = (CW+1)'(nib_q) + (CW+1)'(lz4bd_pkg::MIN_MATCH);
                mmore = 1'b0;
              end
              if (mlen > (CW+1)'(room)) begin
                fcode = lz4bd_pkg::ERR_OVERFLOW;
              end else begin
                mrem_d = mlen[CW-1:0];
                ph_d   = mmore ? PH_MATCH_EXT : PH_COPY;
                bnd    = !mmore;
              end
            end
          end
          PH_MATCH_EXT: begin
            mlen  = (CW+1)'(mrem_d) + (CW+1)'(data_byte_i);
            mmore = (data_byte_i == lz4bd_pkg::EXT_CONT);
            if (mlen > (CW+1)'(room)) begin
              fcode = lz4bd_pkg::ERR_OVERFLOW;
            end else begin
              mrem_d = mlen[CW-1:0];
              ph_d   = mmore ? PH_MATCH_EXT : PH_COPY;
              bnd    = !mmore;
            end
          end
          default: begin
            bnd = 1'b0;
          end
        endcase
        if (fcode == lz4bd_pkg::ERR_NONE && last_i && !bnd) fcode = lz4bd_pkg::ERR_TRUNC;
        if (fcode != lz4bd_pkg::ERR_NONE) begin
          err_d  = fcode;
          ph_d   = PH_TOKEN;
          mrem_d = '0;
          lrem_d = '0;
        end
      end
      if (last_i) end_d = 1'b1;
    end

    step_o.emit  = emit;
    step_o.copy  = copy;
    step_o.lit   = data_byte_i;
    step_o.waddr = waddr;
    step_o.busy  = (ph_d == PH_COPY);
    step_o.done  = end_d && (ph_d != PH_COPY);
    step_o.err   = err_d;
    step_o.len   = wp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_TOKEN;
      nib_q  <= '0;
      lrem_q <= '0;
      mrem_q <= '0;
      off_q  <= '0;
      wp_q   <= '0;
      err_q  <= lz4bd_pkg::ERR_NONE;
      end_q  <= 1'b0;
    end else if (acc_i) begin
      ph_q   <= ph_d;
      nib_q  <= nib_d;
      lrem_q <= lrem_d;
      mrem_q <= mrem_d;
      off_q  <= off_d;
      wp_q   <= wp_d;
      err_q  <= err_d;
      end_q  <= end_d;
    end
  end

endmodule

`default_nettype wire

/* design/lz4bd_hist.sv */
`default_nettype none

module lz4bd_hist (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          acc_i,
  input  wire lz4bd_pkg::step_t              step_i,
  input  wire logic [lz4bd_pkg::HIST_AW-1:0] rd_addr_i,
  input  wire logic                          out_ready_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  output lz4bd_pkg::step_t                   out_o
);

  localparam int unsigned HistDepth = 1 << lz4bd_pkg::HIST_AW;

  logic [7:0] mem [HistDepth];

  logic             s1_v_q;
  lz4bd_pkg::step_t s1_q;
  logic [7:0]       rd_q;
  logic             fwd_q;
  logic [7:0]       fwd_data_q;
  logic             o_v_q;
  lz4bd_pkg::step_t o_q;

  logic             s1_adv;
  logic [7:0]       s1_byte;
  logic             wr_en;
  lz4bd_pkg::step_t s1_out;

  assign s1_adv     = s1_v_q && (!o_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign s1_byte    = s1_q.copy ? (fwd_q ? fwd_data_q : rd_q) : s1_q.lit;
  assign wr_en      = s1_adv && s1_q.emit;

  always_comb begin
    s1_out     = s1_q;
    s1_out.lit = s1_q.emit ? s1_byte : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[s1_q.waddr] <= s1_byte;
    if (acc_i) rd_q <= mem[rd_addr_i];
  end

  // forward the byte written on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q       <= step_i;
      fwd_q      <= wr_en && (s1_q.waddr == rd_addr_i);
      fwd_data_q <= s1_byte;
    end
    if (s1_adv) begin
      o_q <= s1_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (acc_i) s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (s1_adv) o_v_q <= 1'b1;
      else if (out_ready_i) o_v_q <= 1'b0;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_o       = o_q;

endmodule

`default_nettype wire

/* design/lz4bd_checker.sv */
`default_nettype none
`include "lz4_block_decoder_macros.svh"

module lz4bd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       hs_valid_i,
  input wire logic       hs_ready_i,
  input wire logic       out_valid_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       busy_i,
  input wire logic       done_i,
  input wire logic [2:0] err_i
);

  `LZ4BD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, hs_valid_i && !hs_ready_i, hs_valid_i)
  `LZ4BD_ASSERT_NOW(a_idle_byte_zero, clk_i, rst_ni, hs_valid_i && !out_valid_i, out_byte_i == 8'd0)
  `LZ4BD_ASSERT_NOW(a_busy_not_done, clk_i, rst_ni, hs_valid_i, !(busy_i && done_i))
  `LZ4BD_ASSERT_NOW(a_err_range, clk_i, rst_ni, hs_valid_i, err_i <= lz4bd_pkg::ERR_BUSY)

endmodule

bind lz4_block_decoder lz4bd_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .hs_valid_i  (out_o.valid),
  .hs_ready_i  (out_o.ready),
  .out_valid_i (out_o.out_valid),
  .out_byte_i  (out_o.out_byte),
  .busy_i      (out_o.busy_res),
  .done_i      (out_o.block_done),
  .err_i       (out_o.error_code)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
module tb_top;

  localparam bit OP_BYTE = 1'b0;
  localparam bit OP_TICK = 1'b1;
  localparam int unsigned BLOCK_LIMIT = lz4bd_pkg::MAX_BLOCK_DEF;

  typedef enum bit [2:0] {
    ST_TOKEN, ST_LIT_EXT, ST_LITERALS, ST_OFF_LO, ST_OFF_HI, ST_MATCH_EXT, ST_COPY, ST_STORED
  } dec_phase_e;

  typedef struct packed {
    bit                        vld;
    bit [7:0]                  data;
    bit                        busy;
    bit                        done;
    bit [2:0]                  err;
    bit [lz4bd_pkg::CAP_W-1:0] len;
  } dec_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [lz4bd_pkg::CAP_W-1:0] cfg_data;

  lz4bd_in_if  in_if ();
  lz4bd_out_if out_if ();

  lz4_block_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // decoder state as predicted
  bit                        m_stored = 1'b0;
  bit [lz4bd_pkg::CAP_W-1:0] m_cap = lz4bd_pkg::CAP_RESET;
  dec_phase_e                m_phase = ST_TOKEN;
  bit [3:0]                  m_nib = '0;
  int unsigned               m_lit_left = 0;
  int unsigned               m_match_left = 0;
  bit [15:0]                 m_offset = '0;
  bit [lz4bd_pkg::CAP_W-1:0] m_wpos = '0;
  bit [7:0]                  m_hist [65536];
  bit [2:0]                  m_err = lz4bd_pkg::ERR_NONE;
  bit                        m_end = 1'b0;
  bit                        s_vld;
  bit [7:0]                  s_data;

  dec_result_t expected_out_q [$];

  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold_cycles = 0;
  int unsigned useful_items = 0;
  int unsigned result_count = 0;
  int unsigned fail_count = 0;

  function automatic int unsigned room_left();
    int unsigned lim;
    lim = (m_cap > BLOCK_LIMIT) ? BLOCK_LIMIT : m_cap;
    return (m_wpos >= lim) ? 0 : lim - m_wpos;
  endfunction

  function automatic void latch_error(bit [2:0] code);
    if (m_err == lz4bd_pkg::ERR_NONE) m_err = code;
    m_phase = ST_TOKEN;
    m_match_left = 0;
    m_lit_left = 0;
  endfunction

  function automatic void emit_byte(bit [7:0] b);
    m_hist[m_wpos[15:0]] = b;
    m_wpos = m_wpos + 1'b1;
    s_vld = 1'b1;
    s_data = b;
  endfunction

  function automatic void set_match_len(int unsigned len, bit more);
    if (len > room_left()) begin
      latch_error(lz4bd_pkg::ERR_OVERFLOW);
      return;
    end
    m_match_left = len;
    m_phase = more ? ST_MATCH_EXT : ST_COPY;
  endfunction

  // returns 1 when the block may end after this byte
  function automatic bit parse_byte(bit [7:0] b);
    int unsigned n;
    case (m_phase)
      ST_STORED: begin
        if (room_left() == 0) begin
          latch_error(lz4bd_pkg::ERR_OVERFLOW);
          return 1'b0;
        end
        emit_byte(b);
        return 1'b1;
      end
      ST_TOKEN: begin
        m_nib = b[3:0];
        n = b[7:4];
        if (n == 0) begin
          m_phase = ST_OFF_LO;
          return 1'b1;
        end
        if (n > room_left()) begin
          latch_error(lz4bd_pkg::ERR_OVERFLOW);
          return 1'b0;
        end
        m_lit_left = n;
        m_phase = (n == lz4bd_pkg::NIB_EXT) ? ST_LIT_EXT : ST_LITERALS;
        return 1'b0;
      end
      ST_LIT_EXT: begin
        n = m_lit_left + b;
        if (n > room_left()) begin
          latch_error(lz4bd_pkg::ERR_OVERFLOW);
          return 1'b0;
        end
        m_lit_left = n;
        if (b != lz4bd_pkg::EXT_CONT) m_phase = ST_LITERALS;
        return 1'b0;
      end
      ST_LITERALS: begin
        emit_byte(b);
        if (m_lit_left > 0) m_lit_left--;
        if (m_lit_left == 0) begin
          m_phase = ST_OFF_LO;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_OFF_LO: begin
        m_offset = {8'h00, b};
        m_phase = ST_OFF_HI;
        return 1'b0;
      end
      ST_OFF_HI: begin
        m_offset = {b, m_offset[7:0]};
        if (m_offset == 0 || m_offset > m_wpos) begin
          latch_error(lz4bd_pkg::ERR_OFFSET);
          return 1'b0;
        end
        if (m_nib == lz4bd_pkg::NIB_EXT) begin
          set_match_len(lz4bd_pkg::NIB_EXT + lz4bd_pkg::MIN_MATCH, 1'b1);
          return 1'b0;
        end
        set_match_len(m_nib + lz4bd_pkg::MIN_MATCH, 1'b0);
        return m_phase == ST_COPY;
      end
      ST_MATCH_EXT: begin
        set_match_len(m_match_left + b, b == lz4bd_pkg::EXT_CONT);
        return m_phase == ST_COPY;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic dec_result_t predict_decode(bit op, bit [7:0] b, bit last);
    dec_result_t r;
    bit seq_end;
    bit [15:0] src;
    s_vld = 1'b0;
    s_data = 8'h00;
    if (op == OP_TICK) begin
      if (m_phase == ST_COPY && m_err == lz4bd_pkg::ERR_NONE) begin
        src = m_wpos[15:0] - m_offset;
        emit_byte(m_hist[src]);
        if (m_match_left > 0) m_match_left--;
        if (m_match_left == 0) m_phase = ST_TOKEN;
      end
    end else if (m_phase == ST_COPY) begin
      latch_error(lz4bd_pkg::ERR_BUSY);
      if (last) m_end = 1'b1;
    end else begin
      if (m_end) begin
        m_phase = ST_TOKEN;
        m_wpos = '0;
        m_err = lz4bd_pkg::ERR_NONE;
        m_end = 1'b0;
        m_match_left = 0;
        m_lit_left = 0;
      end
      if (m_err == lz4bd_pkg::ERR_NONE) begin
        if (m_phase == ST_TOKEN && m_wpos == 0 && m_stored) m_phase = ST_STORED;
        seq_end = parse_byte(b);
        if (last && !seq_end && m_err == lz4bd_pkg::ERR_NONE) latch_error(lz4bd_pkg::ERR_TRUNC);
      end
      if (last) m_end = 1'b1;
    end
    r.vld = s_vld;
    r.data = s_data;
    r.busy = (m_phase == ST_COPY);
    r.done = m_end && (m_phase != ST_COPY);
    r.err = m_err;
    r.len = m_wpos;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch at result %0d: %s got %0d want %0d", result_count, what, got, want);
  endtask

  task automatic send_item(bit op, bit [7:0] b, bit last);
    int unsigned gap;
    dec_result_t want;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.data_byte <= b;
    in_if.last      <= last;
    do @(posedge clk); while (!in_if.ready);
    if ((op == OP_BYTE && (m_err == lz4bd_pkg::ERR_NONE || m_end)) ||
        (op == OP_TICK && m_phase == ST_COPY))
      useful_items++;
    want = predict_decode(op, b, last);
    expected_out_q.insert(expected_out_q.size(), want);
  endtask

  task automatic send_byte(bit [7:0] b, bit last);
    send_item(OP_BYTE, b, last);
  endtask

  task automatic drain_ticks(int unsigned n);
    repeat (n) send_item(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  task automatic send_ext(int unsigned rem, bit last);
    while (rem >= lz4bd_pkg::EXT_CONT) begin
      send_byte(lz4bd_pkg::EXT_CONT, 1'b0);
      rem -= lz4bd_pkg::EXT_CONT;
    end
    send_byte(rem, last);
  endtask

  task automatic write_cfg(logic idx, bit [lz4bd_pkg::CAP_W-1:0] value);
    in_if.valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lz4bd_pkg::CFG_STORED) m_stored = value[0];
    else m_cap = value;
    @(posedge clk);
  endtask

  task automatic test_basic_match();
    send_byte(8'h3F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    drain_ticks(lz4bd_pkg::NIB_EXT + lz4bd_pkg::MIN_MATCH + 1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_bad_offset();
    send_byte(8'h10, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_truncated_and_busy();
    send_byte(8'h20, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    drain_ticks(1);
    send_byte(8'h55, 1'b1);
  endtask

  task automatic test_overflow();
    write_cfg(lz4bd_pkg::CFG_CAPACITY, 17'd3);
    send_byte(8'h40, 1'b0);
    send_byte(8'h66, 1'b1);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, 17'd20);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h06, 1'b1);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, 17'd6);
    send_byte(8'h21, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_stored_block();
    write_cfg(lz4bd_pkg::CFG_STORED, 17'd1);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, 17'd2);
    send_byte(8'h01, 1'b0);
    drain_ticks(1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b1);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, 17'd0);
    send_byte(8'h3C, 1'b1);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, BLOCK_LIMIT);
    send_byte(8'h7F, 1'b1);
    write_cfg(lz4bd_pkg::CFG_STORED, 17'd0);
  endtask

  task automatic test_capacity_lowered();
    send_byte(8'h30, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h01, 1'b0);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, 17'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h10, 1'b1);
    write_cfg(lz4bd_pkg::CFG_CAPACITY, BLOCK_LIMIT);
  endtask

  task automatic test_backpressure();
    write_cfg(lz4bd_pkg::CFG_STORED, 17'd1);
    tx_burst = 1'b1;
    rx_hold_cycles = 300;
    for (int i = 0; i < 60; i++) send_byte($urandom_range(0, 255), i == 59);
    tx_burst = 1'b0;
    write_cfg(lz4bd_pkg::CFG_STORED, 17'd0);
  endtask

  task automatic test_random_blocks();
    int unsigned goal, lit_len, mat_len, nseq, off, lim, k;
    bit end_on_match;
    goal = useful_items + 300;
    while (useful_items < goal) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 7))
          0: k = 0;
          1: k = $urandom_range(1, 8);
          2, 3: k = $urandom_range(16, 96);
          4: k = $urandom_range(0, BLOCK_LIMIT);
          default: k = BLOCK_LIMIT;
        endcase
        write_cfg(lz4bd_pkg::CFG_CAPACITY, k);
      end
      k = ($urandom_range(0, 4) == 0);
      if (k != m_stored) write_cfg(lz4bd_pkg::CFG_STORED, k);
      tx_burst = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(3, 10);
        repeat (k - 1) send_item($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1));
        send_byte($urandom_range(0, 255), 1'b1);
      end else if (m_stored) begin
        k = $urandom_range(1, 24);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 7) == 0) drain_ticks(1);
          send_byte($urandom_range(0, 255), i == k - 1);
        end
      end else begin : compressed
        nseq = $urandom_range(0, 3);
        for (int s = 0; s < nseq; s++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_byte({4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))}, 1'b1);
            disable compressed;
          end
          lit_len = (s == 0) ? $urandom_range(1, 20) : $urandom_range(0, 20);
          if ($urandom_range(0, 24) == 0)
            lit_len = lz4bd_pkg::NIB_EXT + lz4bd_pkg::EXT_CONT + $urandom_range(0, 20);
          mat_len = $urandom_range(lz4bd_pkg::MIN_MATCH, 24);
          if ($urandom_range(0, 29) == 0)
            mat_len = lz4bd_pkg::MIN_MATCH + lz4bd_pkg::NIB_EXT + lz4bd_pkg::EXT_CONT +
                      $urandom_range(0, 10);
          send_byte({4'((lit_len >= lz4bd_pkg::NIB_EXT) ? lz4bd_pkg::NIB_EXT : lit_len),
                     4'((mat_len - lz4bd_pkg::MIN_MATCH >= lz4bd_pkg::NIB_EXT) ?
                        lz4bd_pkg::NIB_EXT : mat_len - lz4bd_pkg::MIN_MATCH)}, 1'b0);
          if (lit_len >= lz4bd_pkg::NIB_EXT) send_ext(lit_len - lz4bd_pkg::NIB_EXT, 1'b0);
          repeat (lit_len) send_byte($urandom_range(0, 255), 1'b0);
          lim = (m_wpos > 17'hFFFF) ? 32'hFFFF : m_wpos;
          if (lim == 0) off = $urandom_range(0, 16'hFFFF);
          else begin
            case ($urandom_range(0, 14))
              0: off = 0;
              1: off = lim + $urandom_range(1, 50);
              2, 3, 4: off = $urandom_range(1, lim);
              default: off = $urandom_range(1, (lim > 8) ? 8 : lim);
            endcase
          end
          end_on_match = (s == nseq - 1) && ($urandom_range(0, 5) == 0);
          if ($urandom_range(0, 39) == 0) begin
            send_byte(off[7:0], 1'b1);
            disable compressed;
          end
          send_byte(off[7:0], 1'b0);
          send_byte(off[15:8],
                    end_on_match && (mat_len - lz4bd_pkg::MIN_MATCH < lz4bd_pkg::NIB_EXT));
          if (mat_len - lz4bd_pkg::MIN_MATCH >= lz4bd_pkg::NIB_EXT)
            send_ext(mat_len - lz4bd_pkg::MIN_MATCH - lz4bd_pkg::NIB_EXT, end_on_match);
          if ($urandom_range(0, 24) == 0) begin
            drain_ticks($urandom_range(0, mat_len - 1));
            send_byte($urandom_range(0, 255), 1'b1);
            drain_ticks(mat_len);
            disable compressed;
          end
          drain_ticks(mat_len + ($urandom_range(0, 5) == 0));
          if (end_on_match) disable compressed;
        end
        lit_len = $urandom_range(0, 10);
        send_byte({4'(lit_len), 4'($urandom_range(0, 15))}, lit_len == 0);
        for (int i = 0; i < lit_len; i++) send_byte($urandom_range(0, 255), i == lit_len - 1);
      end
    end
    tx_burst = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : result_checker
    dec_result_t want;
    int unsigned gap;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      result_count++;
      if (result_count % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (expected_out_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_out_q.pop_front();
        if (out_if.out_valid !== want.vld) report_mismatch("out_valid", out_if.out_valid, want.vld);
        if (out_if.out_byte !== want.data) report_mismatch("out_byte", out_if.out_byte, want.data);
        if (out_if.busy_res !== want.busy) report_mismatch("busy_res", out_if.busy_res, want.busy);
        if (out_if.block_done !== want.done)
          report_mismatch("block_done", out_if.block_done, want.done);
        if (out_if.error_code !== want.err)
          report_mismatch("error_code", out_if.error_code, want.err);
        if (out_if.decoded_length !== want.len)
          report_mismatch("decoded_length", out_if.decoded_length, want.len);
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= lz4bd_pkg::CFG_STORED;
    cfg_data        <= '0;
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_BYTE;
    in_if.data_byte <= 8'h00;
    in_if.last      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_match();
    test_bad_offset();
    test_truncated_and_busy();
    test_overflow();
    test_stored_block();
    test_capacity_lowered();
    test_backpressure();
    test_random_blocks();

    in_if.valid <= 1'b0;
    for (int i = 0; i < 20000 && expected_out_q.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_out_q.size() != 0) report_mismatch("results missing", 0, expected_out_q.size());
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/lz4bd_pkg.sv
design/lz4bd_in_if.sv
design/lz4bd_out_if.sv
design/lz4bd_parser.sv
design/lz4bd_hist.sv
design/lz4_block_decoder.sv
design/lz4bd_checker.sv
tb/sv/tb_top.sv
